@@ src/cst_pkg.sv @@
package cst_pkg;

  localparam int unsigned MaxPoints   = 512;
  localparam int unsigned MaxClusters = 32;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned EnergyW = 48;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ActW    = 6;

  localparam logic [EnergyW-1:0] EmptyPenalty = 48'd2560000000000;
  localparam logic [ActW-1:0]    ActResetVal  = 6'd20;

  localparam logic [StatusW-1:0] StOk         = 3'd0;
  localparam logic [StatusW-1:0] StNotLoaded  = 3'd1;
  localparam logic [StatusW-1:0] StLoaded     = 3'd2;
  localparam logic [StatusW-1:0] StRange      = 3'd3;
  localparam logic [StatusW-1:0] StBadCmd     = 3'd4;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdMove = 1'b1;

  localparam logic [0:0] RegActive = 1'b0;

endpackage

@@ src/cluster_sse_tracker_top.sv @@
// Incremental k-means energy tracker.
// Input channel (in_valid_i / in_stall_o) takes one request: a load of a new
// point into a cluster or a move of a stored point to another cluster.
// Output channel (out_valid_o / out_stall_i) returns one result per request:
// the energy summed over the active clusters, the cluster the point left and
// a status code. Errored requests leave all stores unchanged.
// Flow: a request reads the point and cluster stores, checks, updates the
// first cluster and then adds a moved point to its target; an errored
// request skips the update and the add. The energy pass then visits each
// active cluster in turn. A nonempty one runs two 48-step restoring
// divisions on one shared divider. in_stall_o stays high until the result
// is loaded into the output register, so a new request is taken only once
// the last one is through.
// Results leave through one output register. While out_stall_i holds it, the
// next request still runs and stalls only when its own result is ready.
// Reset sets active_clusters to 20 and clears the cluster valid bits. It also
// starts a pass over all MAX_POINTS entries (512 by default) that clears the
// loaded flags, with in_stall_o high during the pass.
// Configuration: APB register 0 at address 0 is active_clusters; write only
// while the block is idle.
module cluster_sse_tracker_top #(
  parameter int unsigned MAX_POINTS   = cst_pkg::MaxPoints,
  parameter int unsigned MAX_CLUSTERS = cst_pkg::MaxClusters
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [8:0]  point_index_i,
  input  logic [9:0]  point_x_i,
  input  logic [9:0]  point_y_i,
  input  logic [4:0]  target_cluster_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] energy_o,
  output logic [4:0]  previous_cluster_o,
  output logic [2:0]  status_o
);

  localparam int unsigned PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned KW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SumW = CntW + cst_pkg::CoordW;
  localparam int unsigned SqW  = CntW + 2 * cst_pkg::CoordW;
  // dividend 256*s^2
  localparam int unsigned DivW = 2 * SumW + 8;
  localparam int unsigned DcW  = $clog2(DivW + 1);
  localparam int unsigned EW   = cst_pkg::EnergyW;

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_READ  = 11'b00000000100,
    S_CHK   = 11'b00000001000,
    S_UPD   = 11'b00000010000,
    S_ADD   = 11'b00000100000,
    S_CREAD = 11'b00001000000,
    S_CTERM = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_NEXT  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [cst_pkg::ActW-1:0] act_q;
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr == cst_pkg::RegActive);
  assign prdata = (paddr == cst_pkg::RegActive) ? {26'd0, act_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= cst_pkg::ActResetVal;
    end else if (cfg_we) begin
      act_q <= pwdata[cst_pkg::ActW-1:0];
    end
  end

  logic [KW:0] limit;
  assign limit = ({1'b0, act_q} > (cst_pkg::ActW+1)'(MAX_CLUSTERS)) ?
                 (KW+1)'(MAX_CLUSTERS) : (KW+1)'(act_q);

  // point stores
  logic [cst_pkg::CoordW-1:0] px_mem [MAX_POINTS];
  logic [cst_pkg::CoordW-1:0] py_mem [MAX_POINTS];
  logic [KW-1:0]              asg_mem [MAX_POINTS];
  logic                       ld_mem [MAX_POINTS];
  logic [PW-1:0]              clr_q;

  // cluster stores
  logic [CntW-1:0] cnt_mem [MAX_CLUSTERS];
  logic [SumW-1:0] sx_mem  [MAX_CLUSTERS];
  logic [SumW-1:0] sy_mem  [MAX_CLUSTERS];
  logic [SqW-1:0]  sxx_mem [MAX_CLUSTERS];
  logic [SqW-1:0]  syy_mem [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] cvalid_q;

  // request registers
  logic            cmd_q;
  logic [8:0]      pidx_q;
  logic [PW-1:0]   p_q;
  logic [cst_pkg::CoordW-1:0] x_q, y_q;
  logic [4:0]      tgt_q;
  logic [4:0]      prev_q;
  logic [2:0]      status_q;
  logic            in_rng;
  logic            move_q;

  assign in_rng = (32'(pidx_q) < 32'(MAX_POINTS));

  // read data
  logic [cst_pkg::CoordW-1:0] rx_q, ry_q;
  logic [KW-1:0]              ra_q;
  logic                       ld_q;
  logic [KW-1:0]              ck_q;   // cluster being updated
  logic [KW-1:0]              ck_sel;
  logic [CntW-1:0] rc_q;
  logic [SumW-1:0] rsx_q, rsy_q;
  logic [SqW-1:0]  rsxx_q, rsyy_q;
  logic            rv_q;

  // energy pass
  logic [KW:0]     k_q;
  logic [EW-1:0]   e_q;
  logic [EW-1:0]   term_q;
  logic            half_q;      // 0: x division, 1: y division
  logic [DivW-1:0] dvd_q;
  logic [DivW-1:0] quo;
  logic [CntW-1:0] rem_q;
  logic [CntW-1:0] dvs_q;
  logic [DcW-1:0]  dc_q;
  logic [SumW-1:0] sq_src;
  logic [2*SumW-1:0] sq;

  // result register
  logic            ovalid_q;
  logic            out_load;
  logic [EW-1:0]   oe_q;
  logic [4:0]      oprev_q;
  logic [2:0]      ost_q;

  // shared squarer for the cluster sums: x when a cluster starts, y on reload
  assign sq_src = (state_q == S_DIV) ? rsy_q : rsx_q;
  assign sq = sq_src * sq_src;

  // divider step
  logic [CntW:0] trial;
  assign trial = {rem_q, dvd_q[DivW-1]} - {1'b0, dvs_q};
  assign quo   = {dvd_q[DivW-2:0], ~trial[CntW]};

  assign ck_sel   = (cmd_q == cst_pkg::CmdMove) ? ra_q : KW'(tgt_q);
  assign out_load = (state_q == S_OUT) && (!ovalid_q || !out_stall_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;
  assign energy_o    = oe_q;
  assign previous_cluster_o = oprev_q;
  assign status_o    = ost_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   state_d = (clr_q == PW'(MAX_POINTS - 1)) ? S_IDLE : S_CLR;
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_CHK;
      S_CHK:   state_d = S_UPD;
      S_UPD:   state_d = (status_q == cst_pkg::StOk) ? S_ADD : S_CREAD;
      S_ADD:   state_d = S_CREAD;
      S_CREAD: state_d = (k_q < limit) ? S_CTERM : S_OUT;
      S_CTERM: state_d = (!rv_q || rc_q == '0) ? S_NEXT : S_DIV;
      S_DIV:   state_d = (dc_q == DcW'(1) && half_q) ? S_NEXT : S_DIV;
      S_NEXT:  state_d = S_CREAD;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // cluster update helper values
  logic [CntW-1:0] cc;
  logic [SumW-1:0] csx, csy;
  logic [SqW-1:0]  csxx, csyy;
  assign cc   = rv_q ? rc_q : '0;
  assign csx  = rv_q ? rsx_q : '0;
  assign csy  = rv_q ? rsy_q : '0;
  assign csxx = rv_q ? rsxx_q : '0;
  assign csyy = rv_q ? rsyy_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      cvalid_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + PW'(1);
      end
      if ((state_q == S_UPD && status_q == cst_pkg::StOk) || state_q == S_ADD) begin
        cvalid_q[ck_q] <= 1'b1;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CLR: begin
        ld_mem[clr_q] <= 1'b0;
      end
      S_IDLE: begin
        cmd_q  <= command_i;
        pidx_q <= point_index_i;
        p_q    <= PW'(point_index_i);
        x_q    <= point_x_i;
        y_q    <= point_y_i;
        tgt_q  <= target_cluster_i;
        prev_q <= target_cluster_i;
        half_q <= 1'b0;
      end
      S_READ: begin
        rx_q <= px_mem[p_q];
        ry_q <= py_mem[p_q];
        ra_q <= asg_mem[p_q];
        ld_q <= ld_mem[p_q];
      end
      S_CHK: begin
        if (7'(tgt_q) >= 7'(limit)) begin
          status_q <= cst_pkg::StRange;
        end else if (cmd_q == cst_pkg::CmdLoad) begin
          status_q <= (!in_rng || ld_q) ? cst_pkg::StLoaded : cst_pkg::StOk;
        end else begin
          status_q <= (!in_rng || !ld_q) ? cst_pkg::StNotLoaded : cst_pkg::StOk;
        end
        move_q <= (cmd_q == cst_pkg::CmdMove);
        ck_q   <= ck_sel;
        // prefetch sums of the cluster touched first
        rv_q   <= cvalid_q[ck_sel];
        rc_q   <= cnt_mem[ck_sel];
        rsx_q  <= sx_mem[ck_sel];
        rsy_q  <= sy_mem[ck_sel];
        rsxx_q <= sxx_mem[ck_sel];
        rsyy_q <= syy_mem[ck_sel];
      end
      default: ;
    endcase

    // S_UPD: first cluster update (remove for move, add for load)
    if (state_q == S_UPD && status_q == cst_pkg::StOk) begin
      if (cmd_q == cst_pkg::CmdLoad) begin
        px_mem[p_q]  <= x_q;
        py_mem[p_q]  <= y_q;
        asg_mem[p_q] <= KW'(tgt_q);
        ld_mem[p_q]  <= 1'b1;
        cnt_mem[ck_q] <= cc + CntW'(1);
        sx_mem[ck_q]  <= csx + SumW'(x_q);
        sy_mem[ck_q]  <= csy + SumW'(y_q);
        sxx_mem[ck_q] <= csxx + SqW'(x_q) * SqW'(x_q);
        syy_mem[ck_q] <= csyy + SqW'(y_q) * SqW'(y_q);
      end else begin
        prev_q <= 5'(ra_q);
        asg_mem[p_q] <= KW'(tgt_q);
        cnt_mem[ck_q] <= cc - CntW'(1);
        sx_mem[ck_q]  <= csx - SumW'(rx_q);
        sy_mem[ck_q]  <= csy - SumW'(ry_q);
        sxx_mem[ck_q] <= csxx - SqW'(rx_q) * SqW'(rx_q);
        syy_mem[ck_q] <= csyy - SqW'(ry_q) * SqW'(ry_q);
      end
      ck_q <= KW'(tgt_q);
    end
    // S_ADD: add moved point to target (reads stores written last cycle)
    if (state_q == S_ADD && move_q) begin
      cnt_mem[ck_q] <= (cvalid_q[ck_q] ? cnt_mem[ck_q] : '0) + CntW'(1);
      sx_mem[ck_q]  <= (cvalid_q[ck_q] ? sx_mem[ck_q] : '0) + SumW'(rx_q);
      sy_mem[ck_q]  <= (cvalid_q[ck_q] ? sy_mem[ck_q] : '0) + SumW'(ry_q);
      sxx_mem[ck_q] <= (cvalid_q[ck_q] ? sxx_mem[ck_q] : '0) + SqW'(rx_q) * SqW'(rx_q);
      syy_mem[ck_q] <= (cvalid_q[ck_q] ? syy_mem[ck_q] : '0) + SqW'(ry_q) * SqW'(ry_q);
    end
    if (state_q == S_UPD || state_q == S_ADD) begin
      k_q <= '0;
      e_q <= '0;
    end

    // energy pass
    if (state_q == S_CREAD && k_q < limit) begin
      rv_q   <= cvalid_q[k_q[KW-1:0]];
      rc_q   <= cnt_mem[k_q[KW-1:0]];
      rsx_q  <= sx_mem[k_q[KW-1:0]];
      rsy_q  <= sy_mem[k_q[KW-1:0]];
      rsxx_q <= sxx_mem[k_q[KW-1:0]];
      rsyy_q <= syy_mem[k_q[KW-1:0]];
      half_q <= 1'b0;
    end
    if (state_q == S_CTERM) begin
      if (!rv_q || rc_q == '0) begin
        e_q <= e_q + cst_pkg::EmptyPenalty;
        k_q <= k_q + (KW+1)'(1);
      end else begin
        term_q <= (EW'(rsxx_q) + EW'(rsyy_q)) << 8;
        dvd_q  <= DivW'({sq, 8'd0});
        dvs_q  <= rc_q;
        rem_q  <= '0;
        dc_q   <= DcW'(DivW);
      end
    end
    if (state_q == S_DIV) begin
      if (dc_q == DcW'(1)) begin
        if (!half_q) begin
          term_q <= term_q - EW'(quo);
          dvd_q  <= DivW'({sq, 8'd0});
          rem_q  <= '0;
          dc_q   <= DcW'(DivW);
          half_q <= 1'b1;
        end else begin
          e_q <= e_q + term_q - EW'(quo);
          k_q <= k_q + (KW+1)'(1);
        end
      end else begin
        if (trial[CntW]) begin
          rem_q <= {rem_q[CntW-2:0], dvd_q[DivW-1]};
        end else begin
          rem_q <= trial[CntW-1:0];
        end
        dvd_q <= quo;
        dc_q  <= dc_q - DcW'(1);
      end
    end

    if (out_load) begin
      oe_q    <= e_q;
      oprev_q <= prev_q;
      ost_q   <= status_q;
    end
  end

  logic unused;
  assign unused = ^{pwdata[31:cst_pkg::ActW]};

endmodule

@@ verif/tb_cluster_sse_tracker_top.sv @@
`timescale 1ns / 1ps

module tb_cluster_sse_tracker_top;

  typedef struct packed {
    logic [cst_pkg::EnergyW-1:0] energy;
    logic [4:0]                  prev_cluster;
    logic [cst_pkg::StatusW-1:0] status;
  } outcome_t;

  class cluster_energy_model;
    longint unsigned pt_x[cst_pkg::MaxPoints];
    longint unsigned pt_y[cst_pkg::MaxPoints];
    int unsigned     owner[cst_pkg::MaxPoints];
    bit              loaded[cst_pkg::MaxPoints];
    longint unsigned members[cst_pkg::MaxClusters];
    longint unsigned sx[cst_pkg::MaxClusters];
    longint unsigned sy[cst_pkg::MaxClusters];
    longint unsigned sxx[cst_pkg::MaxClusters];
    longint unsigned syy[cst_pkg::MaxClusters];
    int unsigned     active;
    outcome_t        pending[$];
    int              mismatches;

    function void clear();
      foreach (loaded[i]) loaded[i] = 1'b0;
      foreach (members[k]) begin
        members[k] = 0; sx[k] = 0; sy[k] = 0; sxx[k] = 0; syy[k] = 0;
      end
      active = cst_pkg::ActResetVal;
      mismatches = 0;
    endfunction

    function int unsigned limit();
      return (active > cst_pkg::MaxClusters) ? cst_pkg::MaxClusters : active;
    endfunction

    // Add or drop one point from a cluster's running sums.
    function void adjust(int unsigned k, int unsigned p, bit drop);
      if (drop) begin
        members[k] -= 1; sx[k] -= pt_x[p]; sy[k] -= pt_y[p];
        sxx[k] -= pt_x[p] * pt_x[p]; syy[k] -= pt_y[p] * pt_y[p];
      end else begin
        members[k] += 1; sx[k] += pt_x[p]; sy[k] += pt_y[p];
        sxx[k] += pt_x[p] * pt_x[p]; syy[k] += pt_y[p] * pt_y[p];
      end
    endfunction

    function logic [cst_pkg::EnergyW-1:0] total_sse();
      longint unsigned e, t;
      e = 0;
      for (int unsigned k = 0; k < limit(); k++) begin
        if (members[k] == 0) begin
          e += cst_pkg::EmptyPenalty;
        end else begin
          t = 256 * (sxx[k] + syy[k]);
          t -= (256 * sx[k] * sx[k]) / members[k];
          t -= (256 * sy[k] * sy[k]) / members[k];
          e += t;
        end
      end
      return e[cst_pkg::EnergyW-1:0];
    endfunction

    function void note_request(logic cmd, logic [8:0] idx, logic [9:0] x, logic [9:0] y,
                               logic [4:0] tgt);
      outcome_t r;
      r.prev_cluster = tgt;
      r.status = cst_pkg::StOk;
      if (tgt >= limit()) begin
        r.status = cst_pkg::StRange;
      end else if (cmd == cst_pkg::CmdLoad) begin
        if (loaded[idx]) begin
          r.status = cst_pkg::StLoaded;
        end else begin
          pt_x[idx] = x; pt_y[idx] = y; owner[idx] = tgt; loaded[idx] = 1'b1;
          adjust(tgt, idx, 1'b0);
        end
      end else begin
        if (!loaded[idx]) begin
          r.status = cst_pkg::StNotLoaded;
        end else begin
          r.prev_cluster = 5'(owner[idx]);
          adjust(owner[idx], idx, 1'b1);
          owner[idx] = tgt;
          adjust(tgt, idx, 1'b0);
        end
      end
      r.energy = total_sse();
      pending.push_back(r);
    endfunction

    function void check_result(logic [cst_pkg::EnergyW-1:0] e, logic [4:0] pc,
                               logic [cst_pkg::StatusW-1:0] st);
      outcome_t x;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result energy=%0d prev=%0d status=%0d",
                                       e, pc, st);
        return;
      end
      x = pending.pop_front();
      if (x.energy !== e || x.prev_cluster !== pc || x.status !== st) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp energy=%0d prev=%0d status=%0d,",
                    " got energy=%0d prev=%0d status=%0d"},
                   x.energy, x.prev_cluster, x.status, e, pc, st);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0]  paddr = cst_pkg::RegActive;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = cst_pkg::CmdLoad;
  logic [8:0]  point_index_i = '0;
  logic [9:0]  point_x_i = '0, point_y_i = '0;
  logic [4:0]  target_cluster_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [47:0] energy_o;
  logic [4:0]  previous_cluster_o;
  logic [2:0]  status_o;

  cluster_energy_model sse;
  int  burst_left;
  bit  hold_off_req;
  int  idle_cycles;
  localparam int IdleLimit = 20000;

  cluster_sse_tracker_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: random stall pattern whose density shifts, plus one long hold-off.
  always begin
    int pct;
    bit held;
    pct = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall_i = 1'b1;
        repeat (1000) @(negedge clk_i);
      end
      if ($urandom_range(0, 199) == 0) pct = $urandom_range(0, 3) * 25;
      out_stall_i = ($urandom_range(0, 99) < pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sse.check_result(energy_o, previous_cluster_o, status_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      idle_cycles = 0;
    else if (rst_ni)
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one request; return once accepted, valid left high.
  task automatic send_request(logic cmd, logic [8:0] idx, logic [9:0] x, logic [9:0] y,
                              logic [4:0] tgt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i = 1'b1;
    command_i = cmd; point_index_i = idx; point_x_i = x; point_y_i = y;
    target_cluster_i = tgt;
    do @(posedge clk_i); while (in_stall_o);
    sse.note_request(cmd, idx, x, y, tgt);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sse.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_active(int unsigned val);
    drain();
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = cst_pkg::RegActive; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sse.active = val & 32'h3F;
  endtask

  task automatic random_phase(int unsigned act, int n);
    logic [8:0] idx;
    logic [4:0] tgt;
    logic       cmd;
    int         tries;
    write_active(act);
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 99) < 45) ? cst_pkg::CmdLoad : cst_pkg::CmdMove;
      idx = 9'($urandom());
      // steer most requests toward a legal point
      if ($urandom_range(0, 9) != 0) begin
        tries = 0;
        while (sse.loaded[idx] == (cmd == cst_pkg::CmdLoad) && tries < 64) begin
          idx = 9'($urandom());
          tries++;
        end
      end
      tgt = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(0, act - 1)) : 5'($urandom());
      send_request(cmd, idx, 10'($urandom()), 10'($urandom()), tgt);
    end
  endtask

  initial begin
    sse = new();
    sse.clear();
    burst_left = 0;
    hold_off_req = 1'b0;
    idle_cycles = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, errors, own-cluster move
    send_request(cst_pkg::CmdLoad, 9'd0, 10'd0, 10'd0, 5'd0);
    send_request(cst_pkg::CmdLoad, 9'd511, 10'd1023, 10'd1023, 5'd19);
    send_request(cst_pkg::CmdLoad, 9'd1, 10'd1023, 10'd0, 5'd0);
    send_request(cst_pkg::CmdLoad, 9'd2, 10'h2AA, 10'h155, 5'd7);
    send_request(cst_pkg::CmdLoad, 9'd3, 10'h155, 10'h2AA, 5'd7);
    send_request(cst_pkg::CmdLoad, 9'd0, 10'd5, 10'd5, 5'd1);
    send_request(cst_pkg::CmdMove, 9'd4, 10'd0, 10'd0, 5'd1);
    send_request(cst_pkg::CmdLoad, 9'd5, 10'd9, 10'd9, 5'd20);
    send_request(cst_pkg::CmdMove, 9'd1, 10'd0, 10'd0, 5'd31);
    send_request(cst_pkg::CmdMove, 9'd1, 10'd0, 10'd0, 5'd5);
    send_request(cst_pkg::CmdMove, 9'd1, 10'd0, 10'd0, 5'd5);
    send_request(cst_pkg::CmdMove, 9'd511, 10'h3FF, 10'h3FF, 5'd0);
    send_request(cst_pkg::CmdLoad, 9'd256, 10'd512, 10'd1, 5'd19);
    // shrink: points beyond the active set stay and may be moved out
    write_active(1);
    send_request(cst_pkg::CmdMove, 9'd1, 10'd0, 10'd0, 5'd0);
    send_request(cst_pkg::CmdMove, 9'd2, 10'd0, 10'd0, 5'd1);
    send_request(cst_pkg::CmdLoad, 9'd6, 10'd100, 10'd200, 5'd0);
    write_active(32);
    send_request(cst_pkg::CmdMove, 9'd2, 10'd0, 10'd0, 5'd31);
    send_request(cst_pkg::CmdLoad, 9'd7, 10'd1023, 10'd0, 5'd31);
    send_request(cst_pkg::CmdMove, 9'd256, 10'd0, 10'd0, 5'd31);

    random_phase(3, 200);
    hold_off_req = 1'b1;
    random_phase(2, 200);
    random_phase(32, 110);
    random_phase(1, 150);
    random_phase(5, 220);
    random_phase(8, 220);
    random_phase(4, 220);
    random_phase(16, 160);
    random_phase(6, 200);
    random_phase(20, 150);

    drain();
    if (sse.mismatches == 0 && sse.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
